/* rtl/mpq_pkg.sv */
// mpq_pkg: shared types and codes for the min-first priority queue.
// Used by mpq_cell and min_priority_queue_unit; no dependencies.
package mpq_pkg;

	localparam int DataW = 32;
	localparam int PrioW = 8;
	localparam int OccW  = 8;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef struct packed {
		logic signed [DataW-1:0] data;
		logic [PrioW-1:0]        prio;
	} entry_t;

	// broadcast command to every cell
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t ent;
	} cell_cmd_t;

endpackage

/* rtl/mpq_cell.sv */
// mpq_cell: one slot of the sorted shift array.
// Depends on mpq_pkg. Keeps, takes the new entry, or shifts from a neighbor.
module mpq_cell (
	input  logic              clk,
	input  mpq_pkg::cell_cmd_t cmd,
	input  logic              held,
	input  mpq_pkg::entry_t   left_ent,
	input  logic              left_ins,
	input  mpq_pkg::entry_t   right_ent,
	output mpq_pkg::entry_t   ent,
	output logic              ins
);
	import mpq_pkg::*;

	entry_t ent_q;

	// entry stays in front of a new push with equal or larger priority
	assign ins = held && (ent_q.prio <= cmd.ent.prio);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (!ins) begin
				ent_q <= left_ins ? cmd.ent : left_ent;
			end
		end else if (cmd.pop) begin
			ent_q <= right_ent;
		end
	end

endmodule

/* rtl/min_priority_queue_unit.sv */
// min_priority_queue_unit: top level of the bounded stable min-first queue.
// Depends on mpq_pkg and mpq_cell.
//
// Usage:
//   Request channel (in_valid/in_ready): mode 0 pushes in_data with
//   in_priority, mode 1 pops the entry with the smallest priority; among
//   equal priorities the oldest entry leaves first.
//   Result channel (out_valid/out_ready): one result per request with
//   status (done, full, empty), popped data and priority (zero otherwise)
//   and the occupancy after the request.
//   Entries live in a row of DEPTH cells kept sorted by priority and age.
//   A push goes into place and a pop shifts every cell toward the head as
//   the request is taken, so a result is valid the cycle after its request is taken.
//   Throughput is one request per cycle while results are taken; the result
//   register is the only buffer, so a request is taken while it is empty
//   or being read.
//   Reset empties the queue and drops any pending result.
//   When the receiver stalls, the result holds and in_ready drops.
module min_priority_queue_unit #(
	parameter int DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic signed [mpq_pkg::DataW-1:0] in_data,
	input  logic [mpq_pkg::PrioW-1:0]        in_priority,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic signed [mpq_pkg::DataW-1:0] out_data,
	output logic [mpq_pkg::PrioW-1:0]        out_priority,
	output logic [mpq_pkg::OccW-1:0]         occupancy
);
	import mpq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]          cnt_q;
	logic                   out_valid_q;
	status_t                status_q;
	logic signed [DataW-1:0] out_data_q;
	logic [PrioW-1:0]       out_priority_q;
	logic [OccW-1:0]        occupancy_q;

	logic                   accept;
	logic                   full;
	logic                   empty;
	logic [CW-1:0]          cnt_nxt;
	logic [CW+OccW-1:0]     cnt_ext;
	cell_cmd_t              cmd;
	entry_t                 ents [DEPTH];
	logic [DEPTH-1:0]       ins;
	logic [DEPTH-1:0]       held;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);

	assign cmd.push     = accept && (mode == MODE_PUSH) && !full;
	assign cmd.pop      = accept && (mode == MODE_POP) && !empty;
	assign cmd.ent.data = in_data;
	assign cmd.ent.prio = in_priority;

	always_comb begin
		cnt_nxt = cnt_q;
		if (cmd.push) begin
			cnt_nxt = cnt_q + CW'(1);
		end else if (cmd.pop) begin
			cnt_nxt = cnt_q - CW'(1);
		end
	end

	assign cnt_ext = {{OccW{1'b0}}, cnt_nxt};

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign held[gi] = (cnt_q > CW'(gi));
			if (gi == 0) begin : g_head
				mpq_cell u_cell (
					.clk       (clk),
					.cmd       (cmd),
					.held      (held[gi]),
					.left_ent  (cmd.ent),
					.left_ins  (1'b1),
					.right_ent (ents[gi+1]),
					.ent       (ents[gi]),
					.ins       (ins[gi])
				);
			end else if (gi == DEPTH - 1) begin : g_tail
				mpq_cell u_cell (
					.clk       (clk),
					.cmd       (cmd),
					.held      (held[gi]),
					.left_ent  (ents[gi-1]),
					.left_ins  (ins[gi-1]),
					.right_ent (ents[gi]),
					.ent       (ents[gi]),
					.ins       (ins[gi])
				);
			end else begin : g_mid
				mpq_cell u_cell (
					.clk       (clk),
					.cmd       (cmd),
					.held      (held[gi]),
					.left_ent  (ents[gi-1]),
					.left_ins  (ins[gi-1]),
					.right_ent (ents[gi+1]),
					.ent       (ents[gi]),
					.ins       (ins[gi])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			occupancy_q    <= cnt_ext[OccW-1:0];
			out_data_q     <= '0;
			out_priority_q <= '0;
			if (mode == MODE_PUSH) begin
				status_q <= full ? ST_FULL : ST_DONE;
			end else if (empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q       <= ST_DONE;
				out_data_q     <= ents[0].data;
				out_priority_q <= ents[0].prio;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_data     = out_data_q;
	assign out_priority = out_priority_q;
	assign occupancy    = occupancy_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above DEPTH");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CW'(2)) |-> (ents[0].prio <= ents[1].prio))
		else $error("head cells out of priority order");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_PUSH && full) |=> (out_valid && status == ST_FULL))
		else $error("push into full queue not refused");

	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_POP && !empty) |=>
		(out_valid && status == ST_DONE && cnt_q == $past(cnt_q) - CW'(1)))
		else $error("pop did not remove one entry");
`endif

endmodule
